// File: hw/rtl/jcmw_pkg.sv
// shared types, marker codes and helpers for the codestream marker walker
`timescale 1ns / 1ps

package jcmw_pkg;

  localparam logic [15:0] MK_SOC = 16'hFF4F;
  localparam logic [15:0] MK_SOT = 16'hFF90;
  localparam logic [15:0] MK_SOD = 16'hFF93;
  localparam logic [15:0] MK_EOC = 16'hFFD9;
  localparam logic [15:0] MK_EPH = 16'hFF92;
  localparam logic [7:0]  MK_PREFIX = 8'hFF;
  localparam logic [7:0]  SOC_LOW = 8'h4F;
  localparam logic [7:0]  NOLEN_LO = 8'h30;
  localparam logic [7:0]  NOLEN_HI = 8'h3F;
  localparam logic [15:0] LSOT_LEN = 16'd10;
  localparam logic [15:0] MIN_SEG_LEN = 16'd2;

  typedef enum logic [14:0] {
    PH_SOC0    = 15'b000000000000001,
    PH_SOC1    = 15'b000000000000010,
    PH_MK_HI   = 15'b000000000000100,
    PH_MK_LO   = 15'b000000000001000,
    PH_LEN_HI  = 15'b000000000010000,
    PH_LEN_LO  = 15'b000000000100000,
    PH_SKIP    = 15'b000000001000000,
    PH_SOT     = 15'b000000010000000,
    PH_TH_HI   = 15'b000000100000000,
    PH_TH_LO   = 15'b000001000000000,
    PH_TLEN_HI = 15'b000010000000000,
    PH_TLEN_LO = 15'b000100000000000,
    PH_TSKIP   = 15'b001000000000000,
    PH_BODY    = 15'b010000000000000,
    PH_DONE    = 15'b100000000000000
  } phase_e;

  // one queue entry: a tile-part record, a summary, or both from one byte
  typedef struct packed {
    logic        has_record;
    logic        has_summary;
    logic        sum_ok;
    logic [31:0] sot_pos;
    logic [31:0] hdr_end;
    logic [31:0] body_end;
    logic [15:0] tile;
    logic [7:0]  part;
    logic [7:0]  total;
    logic [31:0] main_hdr_end;
    logic [31:0] eoc_pos;
  } entry_t;

  function automatic logic no_length(input logic [15:0] code);
    logic res;
    res = (code == MK_SOC) || (code == MK_SOD) || (code == MK_EOC) || (code == MK_EPH) ||
          ((code[7:0] >= NOLEN_LO) && (code[7:0] <= NOLEN_HI));
    return res;
  endfunction

endpackage

// File: hw/rtl/jcmw_queue.sv
// short result queue between the byte parser and the output stage
`timescale 1ns / 1ps

module jcmw_queue
  import jcmw_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   count_q, count_d;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: hw/rtl/jcmw_front.sv
// byte parser: walks markers and segments, builds records and the summary
`timescale 1ns / 1ps

module jcmw_front
  import jcmw_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] stream_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        q_full_i,
  output logic        push_o,
  output entry_t      push_data_o
);

  localparam int CW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

  phase_e                 phase_q, phase_d;
  logic [31:0]            stream_length_q;
  logic [OFFSET_BITS-1:0] byte_offset_q, byte_offset_d;
  logic [OFFSET_BITS-1:0] marker_start_q, marker_start_d;
  logic [7:0]             mhb_q, mhb_d;
  logic [3:0]             field_count_q, field_count_d;
  logic [CW-1:0]          skip_until_q, skip_until_d;
  logic [OFFSET_BITS-1:0] sot_off_q, sot_off_d;
  logic [15:0]            tile_q, tile_d;
  logic [31:0]            tile_len_q, tile_len_d;
  logic [7:0]             part_q, part_d;
  logic [7:0]             total_q, total_d;
  logic [OFFSET_BITS-1:0] hdr_seen_q, hdr_seen_d;
  logic                   first_sot_q, first_sot_d;

  logic          in_fire;
  logic [15:0]   pair;
  logic [CW-1:0] sl, o1, seg_end, bend_sum, bend, sum_eoc;
  logic          sum_flag, sum_ok, ended, rec_flag;
  entry_t        ent;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign in_fire     = in_valid_i && !in_stall_o;

  assign pair     = {mhb_q, data_byte_i};
  assign sl       = CW'(stream_length_q);
  assign o1       = CW'(byte_offset_q) + CW'(1);
  assign seg_end  = CW'(marker_start_q) + CW'(pair) + CW'(2);
  assign bend_sum = CW'(sot_off_q) + CW'(tile_len_q);
  assign bend     = (tile_len_q == '0) ? sl : ((bend_sum > sl) ? sl : bend_sum);

  always_comb begin
    phase_d        = phase_q;
    byte_offset_d  = byte_offset_q;
    marker_start_d = marker_start_q;
    mhb_d          = mhb_q;
    field_count_d  = field_count_q;
    skip_until_d   = skip_until_q;
    sot_off_d      = sot_off_q;
    tile_d         = tile_q;
    tile_len_d     = tile_len_q;
    part_d         = part_q;
    total_d        = total_q;
    hdr_seen_d     = hdr_seen_q;
    first_sot_d    = first_sot_q;
    sum_flag       = 1'b0;
    sum_ok         = 1'b1;
    sum_eoc        = sl;
    ended          = 1'b0;
    rec_flag       = 1'b0;
    ent            = '0;

    if (in_fire) begin
      byte_offset_d = byte_offset_q + 1'b1;
      unique case (phase_q)
        PH_SOC0: begin
          if (stream_length_q < 32'd2 || data_byte_i != MK_PREFIX) begin
            sum_flag = 1'b1;
            sum_ok   = 1'b0;
            sum_eoc  = '0;
            ended    = 1'b1;
          end else begin
            phase_d = PH_SOC1;
          end
        end
        PH_SOC1: begin
          if (data_byte_i != SOC_LOW) begin
            sum_flag = 1'b1;
            sum_ok   = 1'b0;
            sum_eoc  = '0;
            ended    = 1'b1;
          end else begin
            phase_d = PH_MK_HI;
          end
        end
        PH_MK_HI, PH_TH_HI: begin
          marker_start_d = byte_offset_q;
          mhb_d          = data_byte_i;
          phase_d        = (phase_q == PH_MK_HI) ? PH_MK_LO : PH_TH_LO;
        end
        PH_MK_LO: begin
          if (pair == MK_EOC) begin
            sum_flag = 1'b1;
            sum_eoc  = CW'(marker_start_q);
            ended    = 1'b1;
          end else if (pair == MK_SOT) begin
            field_count_d = '0;
            phase_d       = PH_SOT;
          end else if (no_length(pair)) begin
            phase_d = PH_MK_HI;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI, PH_TLEN_HI: begin
          mhb_d   = data_byte_i;
          phase_d = (phase_q == PH_LEN_HI) ? PH_LEN_LO : PH_TLEN_LO;
        end
        PH_LEN_LO, PH_TLEN_LO: begin
          skip_until_d = seg_end;
          if (pair < MIN_SEG_LEN || seg_end > sl) begin
            sum_flag = 1'b1;
            ended    = 1'b1;
          end else if (seg_end == o1) begin
            phase_d = (phase_q == PH_LEN_LO) ? PH_MK_HI : PH_TH_HI;
          end else begin
            phase_d = (phase_q == PH_LEN_LO) ? PH_SKIP : PH_TSKIP;
          end
        end
        PH_SKIP, PH_TSKIP, PH_BODY: begin
          if (o1 == skip_until_q) begin
            phase_d = (phase_q == PH_TSKIP) ? PH_TH_HI : PH_MK_HI;
          end
        end
        PH_SOT: begin
          field_count_d = field_count_q + 1'b1;
          unique case (field_count_q)
            4'd0: mhb_d = data_byte_i;
            4'd1: begin
              if (pair != LSOT_LEN) begin
                sum_flag = 1'b1;
                ended    = 1'b1;
              end else begin
                sot_off_d = marker_start_q;
              end
            end
            4'd2: tile_d = {data_byte_i, 8'h00};
            4'd3: tile_d = {tile_q[15:8], data_byte_i};
            4'd4: tile_len_d = {24'h000000, data_byte_i};
            4'd5, 4'd6, 4'd7: tile_len_d = {tile_len_q[23:0], data_byte_i};
            4'd8: part_d = data_byte_i;
            default: begin
              total_d = data_byte_i;
              if (!first_sot_q) begin
                hdr_seen_d  = sot_off_q;
                first_sot_d = 1'b1;
              end
              phase_d = PH_TH_HI;
            end
          endcase
        end
        PH_TH_LO: begin
          if (pair == MK_SOD) begin
            rec_flag = 1'b1;
            if (bend < CW'(marker_start_q) + CW'(2)) begin
              sum_flag = 1'b1;
              ended    = 1'b1;
            end else begin
              skip_until_d = bend;
              phase_d      = (bend == o1) ? PH_MK_HI : PH_BODY;
            end
          end else if (no_length(pair)) begin
            phase_d = PH_TH_HI;
          end else begin
            phase_d = PH_TLEN_HI;
          end
        end
        PH_DONE: ended = 1'b1;
        default: ended = 1'b1;
      endcase

      // last byte of the stream closes the walk
      if (!ended && o1 >= sl) begin
        sum_flag = 1'b1;
        sum_ok   = 1'b1;
        sum_eoc  = sl;
      end
      if (sum_flag) begin
        phase_d = PH_DONE;
      end
    end

    ent.has_record  = rec_flag;
    ent.has_summary = sum_flag;
    ent.sum_ok      = sum_ok;
    if (rec_flag) begin
      ent.sot_pos  = 32'(sot_off_q);
      ent.hdr_end  = 32'(marker_start_q);
      ent.body_end = 32'(bend);
      ent.tile     = tile_q;
      ent.part     = part_q;
      ent.total    = total_q;
    end
    if (sum_flag) begin
      ent.main_hdr_end = sum_ok ? 32'(hdr_seen_d) : 32'h0;
      ent.eoc_pos      = 32'(sum_eoc);
    end
  end

  assign push_o      = rec_flag || sum_flag;
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_SOC0;
      stream_length_q <= 32'd2;
      byte_offset_q   <= '0;
      marker_start_q  <= '0;
      mhb_q           <= '0;
      field_count_q   <= '0;
      skip_until_q    <= '0;
      sot_off_q       <= '0;
      tile_q          <= '0;
      tile_len_q      <= '0;
      part_q          <= '0;
      total_q         <= '0;
      hdr_seen_q      <= '0;
      first_sot_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        stream_length_q <= stream_length_i;
      end
      phase_q        <= phase_d;
      byte_offset_q  <= byte_offset_d;
      marker_start_q <= marker_start_d;
      mhb_q          <= mhb_d;
      field_count_q  <= field_count_d;
      skip_until_q   <= skip_until_d;
      sot_off_q      <= sot_off_d;
      tile_q         <= tile_d;
      tile_len_q     <= tile_len_d;
      part_q         <= part_d;
      total_q        <= total_d;
      hdr_seen_q     <= hdr_seen_d;
      first_sot_q    <= first_sot_d;
    end
  end

`ifndef SYNTHESIS
  a_push_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> in_fire) else $error("result without accepted byte");
  a_done_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE) else $error("walk restarted after summary");
  a_summary_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_data_o.has_summary |=> phase_q == PH_DONE)
    else $error("summary without end of walk");
`endif

endmodule

// File: hw/rtl/jcmw_back.sv
// output stage: expands queue entries into result words and holds them under stall
`timescale 1ns / 1ps

module jcmw_back
  import jcmw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic        walk_ok_o,
  output logic [31:0] sot_position_o,
  output logic [31:0] header_end_position_o,
  output logic [31:0] body_start_o,
  output logic [31:0] body_end_o,
  output logic [15:0] tile_number_o,
  output logic [7:0]  part_number_o,
  output logic [7:0]  part_total_o,
  output logic [31:0] main_header_end_o,
  output logic [31:0] eoc_position_o,
  output logic        last_o
);

  logic        out_valid_q;
  logic        pend_q, pend_d;
  logic        load, emit_rec;
  logic        kind_q, kind_d;
  logic        ok_q, ok_d;
  logic [31:0] sot_q, sot_d;
  logic [31:0] hdr_q, hdr_d;
  logic [31:0] bstart_q, bstart_d;
  logic [31:0] bend_q, bend_d;
  logic [15:0] tile_q, tile_d;
  logic [7:0]  part_q, part_d;
  logic [7:0]  total_q, total_d;
  logic [31:0] mhe_q, mhe_d;
  logic [31:0] eoc_q, eoc_d;

  assign load     = (!out_valid_q || !out_stall_i) && !empty_i;
  assign emit_rec = head_i.has_record && !pend_q;
  assign pop_o    = load && (!emit_rec || !head_i.has_summary);

  always_comb begin
    pend_d   = pend_q;
    kind_d   = 1'b0;
    ok_d     = 1'b0;
    sot_d    = '0;
    hdr_d    = '0;
    bstart_d = '0;
    bend_d   = '0;
    tile_d   = '0;
    part_d   = '0;
    total_d  = '0;
    mhe_d    = '0;
    eoc_d    = '0;
    if (load) begin
      pend_d = emit_rec && head_i.has_summary;
    end
    if (emit_rec) begin
      sot_d    = head_i.sot_pos;
      hdr_d    = head_i.hdr_end;
      bstart_d = head_i.hdr_end + 32'd2;
      bend_d   = head_i.body_end;
      tile_d   = head_i.tile;
      part_d   = head_i.part;
      total_d  = head_i.total;
    end else begin
      kind_d = 1'b1;
      ok_d   = head_i.sum_ok;
      mhe_d  = head_i.main_hdr_end;
      eoc_d  = head_i.eoc_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q <= !empty_i;
      end
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      ok_q     <= ok_d;
      sot_q    <= sot_d;
      hdr_q    <= hdr_d;
      bstart_q <= bstart_d;
      bend_q   <= bend_d;
      tile_q   <= tile_d;
      part_q   <= part_d;
      total_q  <= total_d;
      mhe_q    <= mhe_d;
      eoc_q    <= eoc_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign record_kind_o         = kind_q;
  assign walk_ok_o             = ok_q;
  assign sot_position_o        = sot_q;
  assign header_end_position_o = hdr_q;
  assign body_start_o          = bstart_q;
  assign body_end_o            = bend_q;
  assign tile_number_o         = tile_q;
  assign part_number_o         = part_q;
  assign part_total_o          = total_q;
  assign main_header_end_o     = mhe_q;
  assign eoc_position_o        = eoc_q;
  assign last_o                = kind_q;

`ifndef SYNTHESIS
  a_pend_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !empty_i && head_i.has_summary) else $error("pending summary lost");
  a_pend_follows_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> out_valid_o && !record_kind_o) else $error("summary split without record");
  a_pop_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> load) else $error("entry dropped without output");
`endif

endmodule

// File: hw/rtl/jpeg2000_codestream_marker_walker.sv
// top level of the codestream marker walker
`timescale 1ns / 1ps

// Walks a codestream fed one byte per word on the in channel (in_valid_i,
// in_stall_o, data_byte_i) and returns tile-part records and one closing
// summary on the out channel (out_valid_o, out_stall_i, result fields).
// The stream length register is written on its own channel (cfg_valid_i,
// cfg_ready_o, stream_length_i); the user must write it only while the
// walker is idle, the block itself does not enforce this. Throughput: one
// byte per cycle while in_stall_o is low. A byte that both ends a tile-part
// header and closes the stream yields two result words, the record and
// then the summary. Each result word goes through the result queue and
// then the output register. The queue holds QUEUE_DEPTH entries; when it
// is full the in channel stalls, so a stalled receiver backs up into the
// byte side only after the queue and output register have filled. After
// the summary further bytes are taken and dropped. Reset returns the
// walker to expecting the SOC marker at offset zero, with a length of two.

module jpeg2000_codestream_marker_walker
  import jcmw_pkg::*;
#(
  parameter int OFFSET_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] stream_length_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        record_kind_o,
  output logic        walk_ok_o,
  output logic [31:0] sot_position_o,
  output logic [31:0] header_end_position_o,
  output logic [31:0] body_start_o,
  output logic [31:0] body_end_o,
  output logic [15:0] tile_number_o,
  output logic [7:0]  part_number_o,
  output logic [7:0]  part_total_o,
  output logic [31:0] main_header_end_o,
  output logic [31:0] eoc_position_o,
  output logic        last_o
);

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_in, q_head;

  jcmw_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .stream_length_i(stream_length_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .push_data_o    (q_in)
  );

  jcmw_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty)
  );

  jcmw_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .head_i               (q_head),
    .empty_i              (q_empty),
    .pop_o                (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .record_kind_o        (record_kind_o),
    .walk_ok_o            (walk_ok_o),
    .sot_position_o       (sot_position_o),
    .header_end_position_o(header_end_position_o),
    .body_start_o         (body_start_o),
    .body_end_o           (body_end_o),
    .tile_number_o        (tile_number_o),
    .part_number_o        (part_number_o),
    .part_total_o         (part_total_o),
    .main_header_end_o    (main_header_end_o),
    .eoc_position_o       (eoc_position_o),
    .last_o               (last_o)
  );

endmodule
